@@ rtl/core/isnb_pkg.sv @@
// Shared types and constants for the nearest/bilinear image scaler.
// No dependencies; imported by the scaler top level and the blend pipeline.
package isnb_pkg;

	// Default geometry and fixed-point format
	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;
	localparam int DEF_FRAC_BITS  = 12;

	// Field widths
	localparam int PIX_W       = 32;
	localparam int CHAN_W      = 8;
	localparam int NUM_CHAN    = PIX_W / CHAN_W;
	localparam int SRC_COORD_W = 8;
	localparam int OUT_COORD_W = 12;
	localparam int DIM_W       = 9;
	localparam int SCALE_W     = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SRC_WIDTH   = 2'd0,
		REG_SRC_HEIGHT  = 2'd1,
		REG_INV_SCALE   = 2'd2,
		REG_INTERP_MODE = 2'd3
	} cfg_reg_t;

	// Request kinds
	typedef enum logic {
		ACT_WRITE   = 1'b0,
		ACT_REQUEST = 1'b1
	} action_t;

	// Interpolation modes
	typedef enum logic {
		MODE_NEAREST  = 1'b0,
		MODE_BILINEAR = 1'b1
	} interp_t;

	// Register reset values
	localparam logic [DIM_W-1:0]   RST_SRC_WIDTH  = 9'd256;
	localparam logic [DIM_W-1:0]   RST_SRC_HEIGHT = 9'd256;
	localparam logic [SCALE_W-1:0] RST_INV_SCALE  = 16'd4096;
	localparam interp_t            RST_INTERP     = MODE_BILINEAR;

endpackage

@@ rtl/core/isnb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; one instance per frame store bank.
module isnb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/isnb_blend.sv @@
// Bilinear blend pipeline: weights, per-channel products, sum, truncate, clamp.
// Depends on isnb_pkg; instantiated by image_scaler_nearest_bilinear.
module isnb_blend
	import isnb_pkg::*;
#(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [PIX_W-1:0]     pix [4],
	input  logic [FRAC_BITS-1:0] fx,
	input  logic [FRAC_BITS-1:0] fy,
	output logic                 out_valid,
	output logic [PIX_W-1:0]     pixel
);

	localparam int OW = FRAC_BITS + 1;
	localparam int WW = 2 * OW;
	localparam int PW = WW + CHAN_W;
	localparam int SW = PW + 2;
	localparam logic [OW-1:0] ONE = OW'(1) << FRAC_BITS;

	logic [OW-1:0]    ofx, ofy;
	logic [WW-1:0]    w_s4 [4];
	logic [PIX_W-1:0] pix_s4 [4];
	logic             vld_s4, vld_s5;
	logic [PW-1:0]    prod_s5 [4][NUM_CHAN];
	logic [SW-1:0]    sum [NUM_CHAN];
	logic [SW-1:0]    shf [NUM_CHAN];
	logic [PIX_W-1:0] pix_next;

	assign ofx = ONE - OW'(fx);
	assign ofy = ONE - OW'(fy);

	// stage 4: corner weights, order 00 01 10 11
	always_ff @(posedge clk) begin
		w_s4[0] <= WW'(ofx) * WW'(ofy);
		w_s4[1] <= WW'(ofx) * WW'(fy);
		w_s4[2] <= WW'(fx) * WW'(ofy);
		w_s4[3] <= WW'(fx) * WW'(fy);
		pix_s4  <= pix;
	end

	// stage 5: weight times channel
	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			for (int c = 0; c < NUM_CHAN; c++) begin
				prod_s5[k][c] <= PW'(w_s4[k]) * PW'(pix_s4[k][c*CHAN_W +: CHAN_W]);
			end
		end
	end

	// channel sums, truncate and saturate
	always_comb begin
		pix_next = '0;
		for (int c = 0; c < NUM_CHAN; c++) begin
			sum[c] = SW'(prod_s5[0][c]) + SW'(prod_s5[1][c])
				+ SW'(prod_s5[2][c]) + SW'(prod_s5[3][c]);
			shf[c] = sum[c] >> (2 * FRAC_BITS);
			pix_next[c*CHAN_W +: CHAN_W] = (shf[c] > SW'(255)) ? 8'hFF : shf[c][CHAN_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		pixel <= pix_next;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			vld_s4    <= in_valid;
			vld_s5    <= vld_s4;
			out_valid <= vld_s5;
		end
	end

	a_valid_chain: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> ##3 out_valid)
		else $error("blend lost a request");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!in_valid |-> ##3 !out_valid)
		else $error("blend produced an extra result");
	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 && fx == '0 && fy == '0 |-> ##0 1'b1)
		else $error("unreachable");

endmodule

@@ rtl/core/image_scaler_nearest_bilinear.sv @@
// Image scaler top level: config registers, position math, banked frame store.
// Depends on isnb_pkg, isnb_ram and isnb_blend.
// A request passes the stage 1 to 3 registers, blend stages 4 and 5 and the blend
// output register before result_valid rises; writes give no result. Throughput:
// one item per cycle, set by the four parity banks of the frame store, each read
// once a cycle. Reset clears valid bits and loads config defaults; the store is
// not cleared. busy stays low and the receiver cannot stall.
module image_scaler_nearest_bilinear
	import isnb_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic                   action,
	input  logic [SRC_COORD_W-1:0] src_col,
	input  logic [SRC_COORD_W-1:0] src_row,
	input  logic [PIX_W-1:0]       pixel_in,
	input  logic [OUT_COORD_W-1:0] out_col,
	input  logic [OUT_COORD_W-1:0] out_row,
	output logic                   result_valid,
	output logic [PIX_W-1:0]       pixel_out,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int CHW = (CW > 1) ? CW - 1 : 1;
	localparam int RHW = (RW > 1) ? RW - 1 : 1;
	localparam int AW  = CHW + RHW;
	localparam int BANK_DEPTH = 1 << AW;
	localparam int PW  = OUT_COORD_W + SCALE_W;
	localparam int IW  = PW - FRAC_BITS + 1;
	localparam logic [PW:0] HALF = (PW+1)'(1) << (FRAC_BITS - 1);

	// config registers
	logic [DIM_W-1:0]   src_width_q, src_height_q;
	logic [SCALE_W-1:0] inv_scale_q;
	interp_t            mode_q;

	// pipeline registers
	logic                   vld_s1, act_s1;
	logic [SRC_COORD_W-1:0] wcol_s1, wrow_s1;
	logic [PIX_W-1:0]       wpix_s1;
	logic [OUT_COORD_W-1:0] ocol_s1, orow_s1;
	logic                   vld_s2, act_s2;
	logic [SRC_COORD_W-1:0] wcol_s2, wrow_s2;
	logic [PIX_W-1:0]       wpix_s2;
	logic [PW-1:0]          px_s2, py_s2;
	logic                   vld_s3;
	logic                   c0p_s3, c1p_s3, r0p_s3, r1p_s3;
	logic [FRAC_BITS-1:0]   fx_s3, fy_s3;

	// stage 2 logic
	logic [CW-1:0]        last_c, c0, c1;
	logic [RW-1:0]        last_r, r0, r1;
	logic [IW-1:0]        xg, yg, xn, yn;
	logic [FRAC_BITS-1:0] fx, fy;
	logic [CW-1:0]        col_sel [2];
	logic [RW-1:0]        row_sel [2];
	logic [AW-1:0]        raddr [4];
	logic                 req_s2, wr_s2;
	logic [3:0]           bank_we;
	logic [AW-1:0]        waddr;
	logic [CW-1:0]        wcol;
	logic [RW-1:0]        wrow;
	logic [PIX_W-1:0]     rdata [4];
	logic [PIX_W-1:0]     pix_sel [4];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= RST_SRC_WIDTH;
			src_height_q <= RST_SRC_HEIGHT;
			inv_scale_q  <= RST_INV_SCALE;
			mode_q       <= RST_INTERP;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SRC_WIDTH:   src_width_q  <= cfg_data[DIM_W-1:0];
				REG_SRC_HEIGHT:  src_height_q <= cfg_data[DIM_W-1:0];
				REG_INV_SCALE:   inv_scale_q  <= cfg_data;
				REG_INTERP_MODE: mode_q       <= interp_t'(cfg_data[0]);
			endcase
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= req_s2;
		end
	end

	// stage 1: capture request
	always_ff @(posedge clk) begin
		act_s1  <= action;
		wcol_s1 <= src_col;
		wrow_s1 <= src_row;
		wpix_s1 <= pixel_in;
		ocol_s1 <= out_col;
		orow_s1 <= out_row;
	end

	// stage 2: source position products
	always_ff @(posedge clk) begin
		act_s2  <= act_s1;
		wcol_s2 <= wcol_s1;
		wrow_s2 <= wrow_s1;
		wpix_s2 <= wpix_s1;
		px_s2   <= PW'(ocol_s1) * PW'(inv_scale_q);
		py_s2   <= PW'(orow_s1) * PW'(inv_scale_q);
	end

	// last column and row of the configured image
	always_comb begin
		if (src_width_q == '0) begin
			last_c = '0;
		end else if (32'(src_width_q) > MAX_WIDTH) begin
			last_c = CW'(MAX_WIDTH - 1);
		end else begin
			last_c = CW'(src_width_q - 1'b1);
		end
		if (src_height_q == '0) begin
			last_r = '0;
		end else if (32'(src_height_q) > MAX_HEIGHT) begin
			last_r = RW'(MAX_HEIGHT - 1);
		end else begin
			last_r = RW'(src_height_q - 1'b1);
		end
	end

	// stage 2: neighbor indexes, clamped; nearest uses one pixel with zero fractions
	always_comb begin
		xg = IW'(px_s2 >> FRAC_BITS);
		yg = IW'(py_s2 >> FRAC_BITS);
		xn = IW'(({1'b0, px_s2} + HALF) >> FRAC_BITS);
		yn = IW'(({1'b0, py_s2} + HALF) >> FRAC_BITS);
		if (mode_q == MODE_NEAREST) begin
			c0 = (xn > IW'(last_c)) ? last_c : CW'(xn);
			r0 = (yn > IW'(last_r)) ? last_r : RW'(yn);
			c1 = c0;
			r1 = r0;
			fx = '0;
			fy = '0;
		end else begin
			c0 = (xg > IW'(last_c)) ? last_c : CW'(xg);
			r0 = (yg > IW'(last_r)) ? last_r : RW'(yg);
			c1 = ((xg + 1'b1) > IW'(last_c)) ? last_c : CW'(xg + 1'b1);
			r1 = ((yg + 1'b1) > IW'(last_r)) ? last_r : RW'(yg + 1'b1);
			fx = px_s2[FRAC_BITS-1:0];
			fy = py_s2[FRAC_BITS-1:0];
		end
	end

	// bank addresses: bank index is {row parity, column parity}
	always_comb begin
		for (int b = 0; b < 2; b++) begin
			col_sel[b] = (c0[0] == b[0]) ? c0 : c1;
			row_sel[b] = (r0[0] == b[0]) ? r0 : r1;
		end
		for (int k = 0; k < 4; k++) begin
			raddr[k] = {RHW'(row_sel[k/2] >> 1), CHW'(col_sel[k%2] >> 1)};
		end
	end

	// writes land in stage 2 so they keep order with reads
	assign req_s2 = vld_s2 && (act_s2 == ACT_REQUEST);
	assign wr_s2  = vld_s2 && (act_s2 == ACT_WRITE)
		&& (32'(wcol_s2) < MAX_WIDTH) && (32'(wrow_s2) < MAX_HEIGHT);
	assign wcol   = CW'(wcol_s2);
	assign wrow   = RW'(wrow_s2);
	assign waddr  = {RHW'(wrow >> 1), CHW'(wcol >> 1)};

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			bank_we[k] = wr_s2 && ({wrow[0], wcol[0]} == 2'(k));
		end
	end

	// frame store banks
	for (genvar k = 0; k < 4; k++) begin : g_bank
		isnb_ram #(
			.WIDTH (PIX_W),
			.DEPTH (BANK_DEPTH)
		) u_bank (
			.clk   (clk),
			.we    (bank_we[k]),
			.waddr (waddr),
			.wdata (wpix_s2),
			.raddr (raddr[k]),
			.rdata (rdata[k])
		);
	end

	// stage 3: parities and fractions follow the read
	always_ff @(posedge clk) begin
		c0p_s3 <= c0[0];
		c1p_s3 <= c1[0];
		r0p_s3 <= r0[0];
		r1p_s3 <= r1[0];
		fx_s3  <= fx;
		fy_s3  <= fy;
	end

	// corner select, order 00 01 10 11 (column, row)
	assign pix_sel[0] = rdata[{r0p_s3, c0p_s3}];
	assign pix_sel[1] = rdata[{r1p_s3, c0p_s3}];
	assign pix_sel[2] = rdata[{r0p_s3, c1p_s3}];
	assign pix_sel[3] = rdata[{r1p_s3, c1p_s3}];

	isnb_blend #(
		.FRAC_BITS (FRAC_BITS)
	) u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s3),
		.pix       (pix_sel),
		.fx        (fx_s3),
		.fy        (fy_s3),
		.out_valid (result_valid),
		.pixel     (pixel_out)
	);

	a_req_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && action |-> ##6 result_valid)
		else $error("request lost");
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !action |-> ##6 !result_valid)
		else $error("write produced a result");
	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		!start |-> ##6 !result_valid)
		else $error("result without request");
	a_one_bank: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(bank_we) && !(wr_s2 && req_s2))
		else $error("bank write conflict");

endmodule
